@@ rtl/rau_pkg.sv @@
package rau_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_e;

  localparam int unsigned FieldW = 32;
  localparam int unsigned DenW   = 31;

  // Magnitude width: products of two 32-bit values plus one carry bit.
  localparam int unsigned MagW = 2 * FieldW + 1;

  // One classified job handed from front to back.
  typedef struct packed {
    logic            arith;    // needs reduction
    logic            cmp_less;
    logic            cmp_greater;
    logic            cmp_same;
    logic            neg;      // signs of numerator and denominator differ
    logic [MagW-1:0] nm;
    logic [MagW-1:0] dm;
  } job_t;

  typedef struct packed {
    logic [FieldW-1:0] res_num;
    logic [DenW-1:0]   res_den;
    logic              less;
    logic              greater;
    logic              same;
    logic              undefined;
    logic              overflow;
  } res_t;

endpackage

@@ rtl/rau_if.sv @@
interface rau_in_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     op;
  logic [rau_pkg::FieldW-1:0]     a_num;
  logic [rau_pkg::FieldW-1:0]     a_den;
  logic [rau_pkg::FieldW-1:0]     b_num;
  logic [rau_pkg::FieldW-1:0]     b_den;

  modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic                           valid;
  logic                           ready;
  logic [rau_pkg::FieldW-1:0]     res_num;
  logic [rau_pkg::DenW-1:0]       res_den;
  logic                           less;
  logic                           greater;
  logic                           same;
  logic                           undefined;
  logic                           overflow;

  modport source (output valid, res_num, res_den, less, greater, same, undefined, overflow,
                  input ready);
  modport sink   (input valid, res_num, res_den, less, greater, same, undefined, overflow,
                  output ready);
endinterface

@@ rtl/rational_arith_unit_core.sv @@
// Flow: the front forms four products on one shared 32x32 multiplier and
// hands a job to the queue; the back runs Euclid steps on the bit-serial
// remainder unit plus two exact divisions; compare and unused codes skip
// the divider. The back takes a new job only once its result is accepted,
// since the single shared divider serves one job at a time.
// Reset: rst_ni asynchronous active low clears all control state; queue empty.
module rational_arith_unit_core #(
  parameter int unsigned WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rau_in_if.sink    in_if,
  rau_out_if.source out_if
);
  logic          job_valid, job_ready, q_valid, q_ready, res_valid;
  rau_pkg::job_t job, q_job;
  rau_pkg::res_t res;

  rau_front #(.WIDTH(WIDTH)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .op_i(in_if.op), .a_num_i(in_if.a_num), .a_den_i(in_if.a_den),
    .b_num_i(in_if.b_num), .b_den_i(in_if.b_den),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  rau_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(job_valid), .wr_ready_o(job_ready), .wr_data_i(job),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_job)
  );

  rau_back #(.WIDTH(WIDTH)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(q_valid), .job_ready_o(q_ready), .job_i(q_job),
    .res_valid_o(res_valid), .res_ready_i(out_if.ready), .res_o(res)
  );

  assign out_if.valid     = res_valid;
  assign out_if.res_num   = res.res_num;
  assign out_if.res_den   = res.res_den;
  assign out_if.less      = res.less;
  assign out_if.greater   = res.greater;
  assign out_if.same      = res.same;
  assign out_if.undefined = res.undefined;
  assign out_if.overflow  = res.overflow;

  // Compare results never carry a fraction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && (out_if.less || out_if.greater) |-> out_if.res_den == '0)
    else $error("compare result with fraction");
  // Less and greater are exclusive.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !(out_if.less && out_if.greater))
    else $error("less and greater both set");
  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.res_num))
    else $error("result dropped under stall");
endmodule

@@ rtl/rau_front.sv @@
// Front end: sign-extend operands, form products one after another
// (one 32x32 multiply per cycle), classify and emit one job.
module rau_front #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          op_i,
  input  logic [rau_pkg::FieldW-1:0] a_num_i,
  input  logic [rau_pkg::FieldW-1:0] a_den_i,
  input  logic [rau_pkg::FieldW-1:0] b_num_i,
  input  logic [rau_pkg::FieldW-1:0] b_den_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output rau_pkg::job_t       job_o
);
  localparam int unsigned PW = 2 * WIDTH;
  localparam int unsigned MW = rau_pkg::MagW;

  typedef enum logic [2:0] {S_IDLE, S_P0, S_P1, S_P2, S_BUILD, S_OUT} state_e;

  state_e              state_q;
  logic [2:0]          op_q;
  logic signed [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
  logic signed [PW-1:0] p0_q, p1_q, p2_q;   // an*bd, ad*bn, an*bn; p3 holds ad*bd
  logic signed [PW-1:0] p3_q;

  logic signed [WIDTH-1:0] mx, my;
  logic signed [PW-1:0]    prod;
  logic [MW-1:0]           m1, m2, mn, md, ssum;
  logic                    s1, s2, s2e, sn, sd;
  rau_pkg::job_t           job_d;

  // Shared multiplier: operand select by step.
  always_comb begin
    mx = an_q;
    my = bd_q;
    case (state_q)
      S_P0:    begin mx = an_q; my = bd_q; end
      S_P1:    begin mx = ad_q; my = bn_q; end
      S_P2:    begin mx = an_q; my = bn_q; end
      S_BUILD: begin mx = ad_q; my = bd_q; end
      default: begin mx = an_q; my = bd_q; end
    endcase
    prod = PW'(mx) * PW'(my);
  end

  function automatic logic [MW-1:0] mag(input logic signed [PW-1:0] v);
    logic [PW-1:0] u;
    u = v[PW-1] ? PW'(-v) : PW'(v);
    return MW'(u);
  endfunction

  // Classify using the registered products; p3 holds ad*bd.
  always_comb begin
    job_d = '0;
    m1 = mag(p0_q);
    m2 = mag(p1_q);
    s1 = p0_q[PW-1];
    s2 = p1_q[PW-1];
    s2e = (op_q == rau_pkg::OP_SUB && m2 != '0) ? ~s2 : s2;
    ssum = '0;
    sn = s1;
    if (s1 == s2e) begin
      ssum = m1 + m2; sn = s1;
    end else if (m1 >= m2) begin
      ssum = m1 - m2; sn = s1;
    end else begin
      ssum = m2 - m1; sn = s2e;
    end
    mn = ssum;
    md = mag(p3_q);
    sd = p3_q[PW-1];
    case (op_q)
      rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin end
      rau_pkg::OP_MUL: begin
        mn = mag(p2_q); sn = p2_q[PW-1];
      end
      rau_pkg::OP_DIV: begin
        mn = m1; sn = s1; md = m2; sd = s2;
      end
      default: begin end
    endcase
    job_d.arith = (op_q < rau_pkg::OP_CMP);
    job_d.nm = mn;
    job_d.dm = md;
    job_d.neg = (mn != '0) && (sn != sd);
    if (op_q == rau_pkg::OP_CMP) begin
      job_d.nm = '0;
      job_d.dm = '0;
      job_d.neg = 1'b0;
      job_d.cmp_less = p0_q < p1_q;
      job_d.cmp_greater = p0_q > p1_q;
      job_d.cmp_same = (an_q == bn_q) && (ad_q == bd_q);
    end
  end

  // Sequence input capture, four multiplies and job hand-off.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_P0;
        S_P0:    state_q <= S_P1;
        S_P1:    state_q <= S_P2;
        S_P2:    state_q <= S_BUILD;
        S_BUILD: state_q <= S_OUT;
        S_OUT:   if (job_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q <= op_i;
      an_q <= a_num_i[WIDTH-1:0];
      ad_q <= a_den_i[WIDTH-1:0];
      bn_q <= b_num_i[WIDTH-1:0];
      bd_q <= b_den_i[WIDTH-1:0];
    end
    if (state_q == S_P0) p0_q <= prod;
    if (state_q == S_P1) p1_q <= prod;
    if (state_q == S_P2) p2_q <= prod;
    if (state_q == S_BUILD) p3_q <= prod;
  end

  // Job is combinational from held registers during S_OUT (p3 is ready then).
  assign in_ready_o  = (state_q == S_IDLE);
  assign job_valid_o = (state_q == S_OUT);
  assign job_o       = job_d;
endmodule

@@ rtl/rau_queue.sv @@
// Two-entry job queue between front and back.
module rau_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  rau_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output rau_pkg::job_t rd_data_o
);
  rau_pkg::job_t mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

@@ rtl/rau_back.sv @@
// Back end: Euclidean gcd and two exact divisions, all through one
// restoring divider that retires one quotient bit per cycle.
module rau_back #(
  parameter int unsigned WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  rau_pkg::job_t job_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output rau_pkg::res_t res_o
);
  localparam int unsigned MW = rau_pkg::MagW;
  localparam int unsigned CW = $clog2(MW + 1);
  localparam logic [MW-1:0] Lim = MW'(1) << (WIDTH - 1);

  typedef enum logic [2:0] {S_IDLE, S_GCD, S_DIVN, S_DIVD, S_FIN, S_OUT} state_e;

  state_e        state_q;
  rau_pkg::job_t job_q;
  logic [MW-1:0] x_q, y_q;        // gcd pair
  logic [MW-1:0] dvd_q, quo_q, rem_q, dvs_q;
  logic [CW-1:0] cnt_q;
  logic [MW-1:0] g_q, nq_q;
  rau_pkg::res_t res_q;

  logic [MW:0]   trial;
  logic [MW-1:0] rem_sh;
  logic          ge;
  logic [MW-1:0] nv;
  logic          ovf;
  rau_pkg::res_t fin;
  rau_pkg::res_t seed;

  // One restoring step.
  always_comb begin
    rem_sh = {rem_q[MW-2:0], dvd_q[MW-1]};
    trial  = {rem_q, dvd_q[MW-1]} - {1'b0, dvs_q};
    ge     = ~trial[MW];
  end

  // Seed the result: compare flags, zero over zero.
  always_comb begin
    seed           = '0;
    seed.less      = job_i.cmp_less;
    seed.greater   = job_i.cmp_greater;
    seed.same      = job_i.cmp_same;
    seed.undefined = job_i.arith && job_i.nm == '0 && job_i.dm == '0;
  end

  // Final packing of the reduced fraction.
  always_comb begin
    fin = '0;
    ovf = (job_q.neg ? (nq_q > Lim) : (nq_q > Lim - 1'b1)) || (quo_q > Lim - 1'b1);
    nv  = job_q.neg ? (MW'(0) - nq_q) : nq_q;
    fin.res_num   = rau_pkg::FieldW'($signed(nv[WIDTH-1:0]));
    fin.res_den   = rau_pkg::DenW'(quo_q[WIDTH-2:0]);
    fin.undefined = (quo_q == '0);
    fin.overflow  = ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: if (job_valid_i) state_q <= job_i.arith ? S_GCD : S_OUT;
        S_GCD: begin
          if (y_q == '0 && cnt_q == '0) state_q <= (x_q == '0) ? S_OUT : S_DIVN;
        end
        S_DIVN: if (cnt_q == CW'(MW)) state_q <= S_DIVD;
        S_DIVD: if (cnt_q == CW'(MW)) state_q <= S_FIN;
        S_FIN:  state_q <= S_OUT;
        S_OUT:  if (res_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath: gcd iterations reuse the divider for x mod y.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        job_q <= job_i;
        x_q <= job_i.nm; y_q <= job_i.dm;
        cnt_q <= '0;
        rem_q <= '0; quo_q <= '0;
        dvd_q <= job_i.nm; dvs_q <= job_i.dm;
        res_q <= seed;
      end
      S_GCD: begin
        if (y_q != '0) begin
          if (cnt_q == CW'(MW)) begin
            x_q <= y_q; y_q <= rem_q;
            dvd_q <= y_q; dvs_q <= rem_q;
            rem_q <= '0; cnt_q <= '0;
          end else begin
            rem_q <= ge ? trial[MW-1:0] : rem_sh;
            dvd_q <= {dvd_q[MW-2:0], 1'b0};
            cnt_q <= cnt_q + 1'b1;
          end
        end else begin
          g_q <= x_q;
          dvd_q <= job_q.nm; dvs_q <= x_q;
          rem_q <= '0; quo_q <= '0; cnt_q <= '0;
        end
      end
      S_DIVN, S_DIVD: begin
        if (cnt_q == CW'(MW)) begin
          if (state_q == S_DIVN) begin
            nq_q <= quo_q;
            dvd_q <= job_q.dm; dvs_q <= g_q;
            rem_q <= '0; quo_q <= '0; cnt_q <= '0;
          end
        end else begin
          rem_q <= ge ? trial[MW-1:0] : rem_sh;
          quo_q <= {quo_q[MW-2:0], ge};
          dvd_q <= {dvd_q[MW-2:0], 1'b0};
          cnt_q <= cnt_q + 1'b1;
        end
      end
      S_FIN: res_q <= fin;
      default: begin end
    endcase
  end

  assign job_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;
endmodule
